[sv/smlf_pkg.sv]
// Shared types and constants for the sparse map line fill block.
package smlf_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 256;
    localparam int CELL_BITS  = 32;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [9:0] WIDTH_RESET  = 10'd256;
    localparam logic [8:0] HEIGHT_RESET = 9'd240;

    // Request to the shared divider
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [31:0] mag;
        logic [12:0] span;
    } div_req_t;

endpackage

[sv/smlf_ram.sv]
// Generic single-port RAM with registered read.
module smlf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[sv/smlf_div.sv]
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module smlf_div #(
    parameter int CELL_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  neg,
    input  logic [CELL_BITS-1:0]  mag,
    input  logic [12:0]           span,
    output logic                  done,
    output logic [CELL_BITS-1:0]  quot
);
    localparam int CW = $clog2(CELL_BITS + 1);

    logic [CELL_BITS-1:0] q_reg, q_next;
    logic [12:0]          r_reg, r_next;
    logic [12:0]          d_reg, d_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [13:0]          trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[CELL_BITS-1]};
        if (start)
        begin
            q_next    = mag;
            r_next    = '0;
            d_next    = span;
            neg_next  = neg;
            cnt_next  = CW'(CELL_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit into the remainder
            if (trial >= {1'b0, d_reg})
            begin
                r_next = 13'(trial - {1'b0, d_reg});
                q_next = {q_reg[CELL_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[12:0];
                q_next = {q_reg[CELL_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? CELL_BITS'(-q_reg) : q_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && start |-> 1'b0) else $error("divider restarted while busy");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
endmodule

[sv/sparse_map_line_fill.sv]
// Top level of the sparse map line fill block.
//
// Usage: pulse start with kind/row/col/value while busy is low. A write or
// read of one cell passes the access and response states before the strobe
// (done); read_value and rejected are valid in that single cycle and cannot
// be held off. A new start is taken in the strobe cycle.
// A fill (kind 2) walks every in-use column, then every in-use row, through
// the single-port cell memory. Per line: a set-up step, a read of each
// position scanned, and for each gap after the first anchor a serial
// divide, a write per interior cell and a step to close it; then, with two
// or more anchors, fetches of the edge cells and a write per position up to
// and including the first anchor and after the last one. Every cell is
// scanned twice.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken
// whenever they arrive; they must only be made while busy is low.
// Reset clears the sizes to 256 x 240 and the sequencer; cell memory is
// undefined until written. Every in-use cell must be written before a fill.
// Results are strobed for one cycle; the receiver takes them unconditionally.
module sparse_map_line_fill (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [7:0]         row,
    input  logic [8:0]         col,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic               rejected,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [9:0]         cfg_data
);
    import smlf_pkg::*;

    localparam int CB = CELL_BITS;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int PW = 13;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_ACC   = 12'b000000000010,
        S_RESP  = 12'b000000000100,
        S_LINE  = 12'b000000001000,
        S_SCAN  = 12'b000000010000,
        S_SCANW = 12'b000000100000,
        S_DIV   = 12'b000001000000,
        S_GAP   = 12'b000010000000,
        S_EDGE  = 12'b000100000000,
        S_EDGEW = 12'b001000000000,
        S_EXT   = 12'b010000000000,
        S_NEXT  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [9:0]  w_cfg_reg;
    logic [8:0]  h_cfg_reg;
    logic [PW-1:0] w_eff, h_eff;

    logic [1:0]  kind_reg;
    logic [7:0]  row_reg;
    logic [8:0]  col_reg;
    logic [CB-1:0] val_reg;
    logic        rej_reg;

    logic        pass_reg, pass_next;      // 0 columns, 1 rows
    logic [PW-1:0] line_reg, line_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] seg_reg, seg_next;      // segment start position
    logic [CB-1:0] seg_val_reg, seg_val_next;
    logic [PW-1:0] first_reg, first_next;
    logic [PW-1:0] last_reg, last_next;
    logic [9:0]  seen_reg, seen_next;
    logic [CB-1:0] slope_reg, slope_next;
    logic [CB-1:0] acc_reg, acc_next;
    logic [1:0]  ephase_reg, ephase_next;  // edge value fetch step
    logic [CB-1:0] f_reg, f_next, fs_reg, fs_next, l_reg, l_next, ls_reg, ls_next;
    logic        done_reg, done_next;
    logic [CB-1:0] rd_reg, rd_next;
    logic        rejo_reg, rejo_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [CB-1:0] ram_wdata, ram_rdata;

    div_req_t    dreq;
    logic        div_done;
    logic [CB-1:0] div_q;

    logic [PW-1:0] line_len, line_cnt;
    logic [PW-1:0] addr_pos;
    logic [CB-1:0] diff;

    assign w_eff = (w_cfg_reg > 10'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(w_cfg_reg);
    assign h_eff = (h_cfg_reg > 9'(MAX_HEIGHT)) ? PW'(MAX_HEIGHT) : PW'(h_cfg_reg);
    assign line_len = pass_reg ? w_eff : h_eff;
    assign line_cnt = pass_reg ? h_eff : w_eff;

    smlf_ram #(.WIDTH(CB), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    smlf_div #(.CELL_BITS(CB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dreq.start),
        .neg   (dreq.neg),
        .mag   (dreq.mag),
        .span  (dreq.span),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_cfg_reg <= WIDTH_RESET;
            h_cfg_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_WIDTH)
            begin
                w_cfg_reg <= cfg_data;
            end
            else
            begin
                h_cfg_reg <= cfg_data[8:0];
            end
        end
    end
    assign cfg_ready = 1'b1;

    assign diff = CB'(ram_rdata - seg_val_reg);

    // Memory address: accesses use row/col, fill uses line and position.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = acc_reg;
        addr_pos  = pos_reg;
        if (state_reg == S_GAP)
        begin
            addr_pos = seg_reg;
        end
        if (state_reg == S_EDGE)
        begin
            unique case (ephase_reg)
                2'd0: addr_pos = first_reg;
                2'd1: addr_pos = PW'(first_reg + 1'b1);
                2'd2: addr_pos = last_reg;
                default: addr_pos = PW'(last_reg - 1'b1);
            endcase
        end
        if (state_reg == S_ACC)
        begin
            ram_addr = {row_reg[YW-1:0], col_reg[XW-1:0]};
            ram_we   = (kind_reg == KIND_WRITE) && !rej_reg;
            ram_wdata = val_reg;
        end
        else if (pass_reg)
        begin
            ram_addr = {line_reg[YW-1:0], addr_pos[XW-1:0]};
        end
        else
        begin
            ram_addr = {addr_pos[YW-1:0], line_reg[XW-1:0]};
        end
        // leave the end anchor alone when the gap walk reaches it
        if ((state_reg == S_GAP && seg_reg != pos_reg) || state_reg == S_EXT)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        line_next    = line_reg;
        pos_next     = pos_reg;
        seg_next     = seg_reg;
        seg_val_next = seg_val_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        seen_next    = seen_reg;
        slope_next   = slope_reg;
        acc_next     = acc_reg;
        ephase_next  = ephase_reg;
        f_next       = f_reg;
        fs_next      = fs_reg;
        l_next       = l_reg;
        ls_next      = ls_reg;
        done_next    = 1'b0;
        rd_next      = rd_reg;
        rejo_next    = rejo_reg;
        dreq.start   = 1'b0;
        dreq.neg     = diff[CB-1];
        dreq.mag     = diff[CB-1] ? CB'(-diff) : diff;
        dreq.span    = PW'(pos_reg - seg_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_FILL)
                    begin
                        pass_next  = 1'b0;
                        line_next  = '0;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        state_next = S_ACC;
                    end
                end
            end
            S_ACC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                done_next  = 1'b1;
                rejo_next  = rej_reg;
                rd_next    = (kind_reg == KIND_READ && !rej_reg) ? ram_rdata : '0;
                state_next = S_IDLE;
            end
            S_NEXT:
            begin
                // advance to the next line, or to rows, or finish
                if (line_reg < line_cnt)
                begin
                    pos_next   = '0;
                    seg_next   = '0;
                    first_next = '0;
                    last_next  = '0;
                    seen_next  = '0;
                    state_next = S_LINE;
                end
                else if (!pass_reg)
                begin
                    pass_next = 1'b1;
                    line_next = '0;
                end
                else
                begin
                    done_next  = 1'b1;
                    rejo_next  = 1'b0;
                    rd_next    = '0;
                    state_next = S_IDLE;
                end
            end
            S_LINE:
            begin
                if (pos_reg < line_len)
                begin
                    state_next = S_SCAN;
                end
                else if (seen_reg >= 10'd2)
                begin
                    ephase_next = 2'd0;
                    state_next  = S_EDGE;
                end
                else
                begin
                    line_next  = PW'(line_reg + 1'b1);
                    state_next = S_NEXT;
                end
            end
            S_SCAN:
            begin
                state_next = S_SCANW;
            end
            S_SCANW:
            begin
                if (ram_rdata == '0)
                begin
                    pos_next   = PW'(pos_reg + 1'b1);
                    state_next = S_LINE;
                end
                else if (seen_reg == '0)
                begin
                    first_next   = pos_reg;
                    seg_next     = pos_reg;
                    seg_val_next = ram_rdata;
                    seen_next    = 10'd1;
                    pos_next     = PW'(pos_reg + 1'b1);
                    state_next   = S_LINE;
                end
                else
                begin
                    dreq.start = 1'b1;
                    acc_next   = ram_rdata;    // hold the end value
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    slope_next = div_q;
                    acc_next   = CB'(seg_val_reg + div_q);
                    f_next     = acc_reg;
                    seg_next   = PW'(seg_reg + 1'b1);
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                // write interior cells; seg_reg walks the gap
                if (seg_reg == pos_reg)
                begin
                    seg_val_next = f_reg;
                    last_next    = pos_reg;
                    if (seen_reg != 10'd1023)
                    begin
                        seen_next = 10'(seen_reg + 1'b1);
                    end
                    pos_next   = PW'(pos_reg + 1'b1);
                    state_next = S_LINE;
                end
                else
                begin
                    acc_next = CB'(acc_reg + slope_reg);
                    seg_next = PW'(seg_reg + 1'b1);
                end
            end
            S_EDGE:
            begin
                state_next = S_EDGEW;
            end
            S_EDGEW:
            begin
                unique case (ephase_reg)
                    2'd0: f_next = ram_rdata;
                    2'd1: fs_next = CB'(ram_rdata - f_reg);
                    2'd2: l_next = ram_rdata;
                    default: ls_next = CB'(l_reg - ram_rdata);
                endcase
                if (ephase_reg == 2'd3)
                begin
                    pos_next   = '0;
                    acc_next   = CB'(f_reg - CB'(fs_reg * CB'(first_reg)));
                    state_next = S_EXT;
                end
                else
                begin
                    ephase_next = 2'(ephase_reg + 1'b1);
                    state_next  = S_EDGE;
                end
            end
            S_EXT:
            begin
                // walk positions, writing outside the anchors, else rewrite
                if (pos_reg < first_reg)
                begin
                    acc_next = CB'(acc_reg + fs_reg);
                end
                if (PW'(pos_reg + 1'b1) == first_reg)
                begin
                    acc_next = f_reg;
                end
                if (PW'(pos_reg + 1'b1) > first_reg)
                begin
                    pos_next = (PW'(pos_reg + 1'b1) > last_reg) ?
                               PW'(pos_reg + 1'b1) : PW'(last_reg + 1'b1);
                    if (PW'(pos_reg + 1'b1) <= last_reg)
                    begin
                        acc_next = CB'(l_reg + ls_reg);
                    end
                    else
                    begin
                        acc_next = CB'(acc_reg + ls_reg);
                    end
                end
                else
                begin
                    pos_next = PW'(pos_reg + 1'b1);
                end
                if (PW'(pos_next) >= line_len)
                begin
                    line_next  = PW'(line_reg + 1'b1);
                    state_next = S_NEXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            pass_reg  <= 1'b0;
            line_reg  <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pass_reg  <= pass_next;
            line_reg  <= line_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            kind_reg <= kind;
            row_reg  <= row;
            col_reg  <= col;
            val_reg  <= CB'(value);
            rej_reg  <= (kind == KIND_WRITE || kind == KIND_READ) &&
                        (PW'(row) >= h_eff || PW'(col) >= w_eff);
        end
        pos_reg     <= pos_next;
        seg_reg     <= seg_next;
        seg_val_reg <= seg_val_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        slope_reg   <= slope_next;
        acc_reg     <= acc_next;
        ephase_reg  <= ephase_next;
        f_reg       <= f_next;
        fs_reg      <= fs_next;
        l_reg       <= l_next;
        ls_reg      <= ls_next;
        rd_reg      <= rd_next;
        rejo_reg    <= rejo_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = signed'(rd_reg[31:0]);
    assign rejected   = rejo_reg;

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE) else $error("result while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("transfer not taken");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_we) else $error("memory write while idle");
endmodule

[tb/sparse_map_line_fill_tb.sv]
// Self-checking testbench for the sparse map line fill block.
module sparse_map_line_fill_tb;
    import smlf_pkg::*;

    localparam int MAP_W      = 512;
    localparam int MAP_H      = 256;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic [31:0] read_value;
        logic        rejected;
    } cell_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic [7:0]         row;
    logic [8:0]         col;
    logic signed [31:0] value;
    logic               done;
    logic signed [31:0] read_value;
    logic               rejected;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [9:0]         cfg_data;

    // Shadow of the block state
    logic [31:0]  map_cells [0:MAP_W*MAP_H-1];
    bit           cell_written [0:MAP_W*MAP_H-1];
    logic [9:0]   width_reg;
    logic [8:0]   height_reg;

    cell_result_t pending_results [$];
    int           error_count;
    int           items_sent;
    int           fills_sent;
    int           results_seen;
    int           sender_idle_pct;
    int           stall_cycles;

    sparse_map_line_fill dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .row        (row),
        .col        (col),
        .value      (value),
        .done       (done),
        .read_value (read_value),
        .rejected   (rejected),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        begin
            $display("MISMATCH @%0t: %s", $time, msg);
            error_count++;
        end
    endtask

    function automatic int used_width();
        return (width_reg > MAP_W) ? MAP_W : int'(width_reg);
    endfunction

    function automatic int used_height();
        return (height_reg > MAP_H) ? MAP_H : int'(height_reg);
    endfunction

    function automatic logic [31:0] trunc_quot(input logic [31:0] x, input int d);
        logic [31:0] mag;
        logic [31:0] q;
        begin
            mag = x[31] ? (32'd0 - x) : x;
            q   = mag / d;
            return x[31] ? (32'd0 - q) : q;
        end
    endfunction

    task automatic fill_line(input int base, input int stride, input int n);
        int seg;
        int first;
        int last;
        int seen;
        logic [31:0] v;
        logic [31:0] a;
        logic [31:0] slope;
        logic [31:0] f;
        logic [31:0] fs;
        logic [31:0] l;
        logic [31:0] ls;
        begin
            seg = 0;
            first = 0;
            last = 0;
            seen = 0;
            for (int p = 0; p < n; p++)
            begin
                v = map_cells[base + p*stride];
                if (v != 0)
                begin
                    if (seen == 0)
                        first = p;
                    else
                    begin
                        a = map_cells[base + seg*stride];
                        slope = trunc_quot(v - a, p - seg);
                        for (int k = seg + 1; k < p; k++)
                            map_cells[base + k*stride] = a + slope * 32'(k - seg);
                        last = p;
                    end
                    seg = p;
                    if (seen < 1023)
                        seen++;
                end
            end
            if (seen >= 2)
            begin
                f  = map_cells[base + first*stride];
                fs = map_cells[base + (first+1)*stride] - f;
                l  = map_cells[base + last*stride];
                ls = l - map_cells[base + (last-1)*stride];
                for (int k = 0; k < first; k++)
                    map_cells[base + k*stride] = f - fs * 32'(first - k);
                for (int k = last + 1; k < n; k++)
                    map_cells[base + k*stride] = l + ls * 32'(k - last);
            end
        end
    endtask

    // Apply one accepted command to the shadow map and queue its result
    task automatic predict_command(input logic [1:0] k, input logic [7:0] r,
                                   input logic [8:0] c, input logic [31:0] v);
        cell_result_t res;
        int w;
        int h;
        int idx;
        begin
            w = used_width();
            h = used_height();
            res.read_value = '0;
            res.rejected = 1'b0;
            if (k == KIND_WRITE || k == KIND_READ)
            begin
                if (int'(r) >= h || int'(c) >= w)
                    res.rejected = 1'b1;
                else
                begin
                    idx = int'(r) * MAP_W + int'(c);
                    if (k == KIND_WRITE)
                    begin
                        map_cells[idx] = v;
                        cell_written[idx] = 1'b1;
                    end
                    else
                        res.read_value = map_cells[idx];
                end
            end
            else if (k == KIND_FILL)
            begin
                for (int i = 0; i < w; i++)
                    fill_line(i, MAP_W, h);
                for (int i = 0; i < h; i++)
                    fill_line(i * MAP_W, 1, w);
            end
            pending_results.insert(pending_results.size(), res);
        end
    endtask

    // Send one command; called just after a rising edge
    task automatic send_command(input logic [1:0] k, input logic [7:0] r,
                                input logic [8:0] c, input logic [31:0] v);
        begin
            if ($urandom_range(99) < sender_idle_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            start <= 1'b1;
            kind  <= k;
            row   <= r;
            col   <= c;
            value <= v;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            predict_command(k, r, c, v);
            items_sent++;
            if (k == KIND_FILL)
                fills_sent++;
        end
    endtask

    // Drain outstanding results so the block is idle
    task automatic settle();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_results.size() != 0 || busy)
                @(posedge clk);
            repeat (5) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic idx, input logic [9:0] data);
        begin
            settle();
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            if (idx == REG_WIDTH)
                width_reg = data;
            else
                height_reg = data[8:0];
        end
    endtask

    task automatic set_size(input logic [9:0] w, input logic [9:0] h);
        begin
            write_register(REG_WIDTH, w);
            write_register(REG_HEIGHT, h);
        end
    endtask

    function automatic logic [31:0] random_cell_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'd0;
            4:          return $urandom;
            5:          return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default:    return 32'($signed($urandom_range(400)) - 200);
        endcase
    endfunction

    // Write every in-use cell, so no fill or read touches an unwritten cell
    task automatic write_all_cells();
        begin
            for (int r = 0; r < used_height(); r++)
                for (int c = 0; c < used_width(); c++)
                    send_command(KIND_WRITE, 8'(r), 9'(c), random_cell_value());
        end
    endtask

    // Read a random cell; an in-use cell is read only once it holds a value
    task automatic random_read(input bit anywhere);
        logic [7:0] r;
        logic [8:0] c;
        begin
            if (anywhere)
            begin
                r = 8'($urandom);
                c = 9'($urandom);
            end
            else
            begin
                r = 8'($urandom_range(used_height() - 1));
                c = 9'($urandom_range(used_width() - 1));
            end
            if (int'(r) < used_height() && int'(c) < used_width() &&
                !cell_written[int'(r) * MAP_W + int'(c)])
                send_command(KIND_WRITE, r, c, $urandom);
            else
                send_command(KIND_READ, r, c, $urandom);
        end
    endtask

    task automatic test_directed();
        begin
            send_command(KIND_WRITE, 8'd0, 9'd0, 32'h8000_0000);
            send_command(KIND_WRITE, 8'd239, 9'd255, 32'h7FFF_FFFF);
            send_command(KIND_READ, 8'd0, 9'd0, 32'd0);
            send_command(KIND_READ, 8'd239, 9'd255, 32'hFFFF_FFFF);
            send_command(KIND_WRITE, 8'd240, 9'd0, 32'h1234_5678);
            send_command(KIND_WRITE, 8'd0, 9'd256, 32'h1234_5678);
            send_command(KIND_READ, 8'd255, 9'd511, 32'd0);
            send_command(2'd3, 8'hFF, 9'h1FF, 32'hFFFF_FFFF);
            // Small map: interior gaps, truncation toward zero, wrap, short lines
            set_size(10'd5, 10'd3);
            send_command(KIND_WRITE, 8'd0, 9'd0, 32'd10);
            send_command(KIND_WRITE, 8'd0, 9'd1, 32'd0);
            send_command(KIND_WRITE, 8'd0, 9'd2, 32'd0);
            send_command(KIND_WRITE, 8'd0, 9'd3, 32'd3);
            send_command(KIND_WRITE, 8'd0, 9'd4, 32'd0);
            send_command(KIND_WRITE, 8'd1, 9'd0, 32'd0);
            send_command(KIND_WRITE, 8'd1, 9'd1, 32'h7FFF_FFF0);
            send_command(KIND_WRITE, 8'd1, 9'd2, 32'd0);
            send_command(KIND_WRITE, 8'd1, 9'd3, 32'h8000_0010);
            send_command(KIND_WRITE, 8'd1, 9'd4, 32'd0);
            for (int c = 0; c < 5; c++)
                send_command(KIND_WRITE, 8'd2, 9'(c), (c == 2) ? 32'hFFFF_FFF9 : 32'd0);
            send_command(KIND_FILL, 8'd0, 9'd0, 32'd0);
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 5; c++)
                    send_command(KIND_READ, 8'(r), 9'(c), 32'd0);
        end
    endtask

    task automatic test_size_extremes();
        begin
            // Zero size rejects everything and a fill does nothing
            set_size(10'd0, 10'd0);
            send_command(KIND_WRITE, 8'd0, 9'd0, 32'd5);
            send_command(KIND_READ, 8'd0, 9'd0, 32'd0);
            send_command(KIND_FILL, 8'd0, 9'd0, 32'd0);
            // Oversized registers clamp to the full map
            set_size(10'h3FF, 10'h3FF);
            send_command(KIND_WRITE, 8'd255, 9'd511, 32'hA5A5_5A5A);
            send_command(KIND_READ, 8'd255, 9'd511, 32'd0);
            set_size(10'd512, 10'd256);
            send_command(KIND_READ, 8'd255, 9'd511, 32'd0);
            send_command(KIND_WRITE, 8'd128, 9'd300, 32'h5A5A_A5A5);
            send_command(KIND_READ, 8'd128, 9'd300, 32'd0);
            // Single column and single row maps
            set_size(10'd1, 10'd4);
            write_all_cells();
            send_command(KIND_FILL, 8'd0, 9'd0, 32'd0);
            for (int r = 0; r < 4; r++)
                send_command(KIND_READ, 8'(r), 9'd0, 32'd0);
            send_command(KIND_READ, 8'd0, 9'd1, 32'd0);
            set_size(10'd6, 10'd1);
            write_all_cells();
            send_command(KIND_FILL, 8'd0, 9'd0, 32'd0);
            for (int c = 0; c < 6; c++)
                send_command(KIND_READ, 8'd0, 9'(c), 32'd0);
            set_size(10'd2, 10'd2);
            write_all_cells();
            send_command(KIND_FILL, 8'd0, 9'd0, 32'd0);
            for (int i = 0; i < 4; i++)
                send_command(KIND_READ, 8'(i / 2), 9'(i % 2), 32'd0);
        end
    endtask

    // Random rounds of write-all, fill, read-back, with noise mixed in
    task automatic test_random_fills(input int item_goal);
        int goal;
        int n;
        begin
            goal = items_sent + item_goal;
            while (items_sent < goal)
            begin
                if ($urandom_range(7) == 0)
                    set_size(10'($urandom_range(1023)), 10'($urandom_range(3)));
                else
                    set_size(10'($urandom_range(2, 10)), 10'($urandom_range(2, 8)));
                if (used_width() * used_height() > 40)
                begin
                    repeat (6) random_read(1'b1);
                    continue;
                end
                write_all_cells();
                if (used_width() > 0 && used_height() > 0)
                begin
                    send_command(KIND_FILL, 8'($urandom), 9'($urandom), $urandom);
                    n = used_width() * used_height() / 2 + 1;
                    repeat (n) random_read(1'b0);
                end
                repeat ($urandom_range(1, 3))
                begin
                    case ($urandom_range(2))
                        0: random_read(1'b1);
                        1: send_command(2'd3, 8'($urandom), 9'($urandom), $urandom);
                        default: send_command(KIND_WRITE, 8'($urandom_range(128, 255)),
                                              9'($urandom), $urandom);
                    endcase
                end
            end
        end
    endtask

    // Compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        cell_result_t exp_res;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result strobed with nothing expected");
            else
            begin
                exp_res = pending_results.pop_front();
                if (read_value !== exp_res.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              read_value, exp_res.read_value));
                if (rejected !== exp_res.rejected)
                    report_mismatch($sformatf("rejected %b, expected %b",
                                              rejected, exp_res.rejected));
            end
        end
    end

    // Stop the run if nothing transfers for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_WRITE;
        row = '0;
        col = '0;
        value = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        stall_cycles = 0;
        error_count = 0;
        items_sent = 0;
        fills_sent = 0;
        results_seen = 0;
        sender_idle_pct = 20;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        for (int i = 0; i < MAP_W*MAP_H; i++)
        begin
            map_cells[i] = '0;
            cell_written[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_size_extremes();
        sender_idle_pct = 20;
        test_random_fills(240);
        sender_idle_pct = 81;
        test_random_fills(240);
        sender_idle_pct = 0;
        test_random_fills(240);

        settle();
        repeat (20) @(posedge clk);
        $display("covered %0d commands (%0d fills), %0d results checked",
                 items_sent, fills_sent, results_seen);
        $display("sizes from empty to full map, sender idling at 20, 81 and 0 percent");
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
sv/smlf_pkg.sv
sv/smlf_ram.sv
sv/smlf_div.sv
sv/sparse_map_line_fill.sv
tb/sparse_map_line_fill_tb.sv
